// ----- hw/rtl/rss_pkg.sv -----
// Shared types, mode codes and pattern tables for the RGB step scaler.
`timescale 1ns / 1ps
`default_nettype none

package rss_pkg;

    // Scale mode codes: 1..8 are integer factors
    typedef logic [3:0] mode_t;
    localparam mode_t MODE_HALF = 4'd0;
    localparam mode_t MODE_F32  = 4'd9;
    localparam mode_t MODE_F52  = 4'd10;
    localparam mode_t MODE_F72  = 4'd11;

    // Horizontal blend kinds over a held pixel a and current pixel b
    typedef logic [2:0] kind_t;
    localparam kind_t K_A = 3'd0;   // a
    localparam kind_t K_L = 3'd1;   // (3a+b)/4
    localparam kind_t K_M = 3'd2;   // (a+b)/2
    localparam kind_t K_R = 3'd3;   // (a+3b)/4
    localparam kind_t K_B = 3'd4;   // b

    // Output run patterns
    typedef logic [2:0] pat_t;
    localparam pat_t PAT_COPY = 3'd0;
    localparam pat_t PAT_HALF = 3'd1;
    localparam pat_t PAT_F32  = 3'd2;
    localparam pat_t PAT_F52  = 3'd3;
    localparam pat_t PAT_F72  = 3'd4;

    // Per-result control for one channel lane
    typedef struct packed {
        kind_t      kind;
        mode_t      vmode;
        logic [2:0] phase;
    } rss_lane_ctrl_t;

    // Marker flags handed to the output stage
    typedef struct packed {
        logic last_of_run;
        logic end_of_row;
    } rss_flags_t;

    // Pick the scale mode for a source size against a target size
    function automatic mode_t pick_mode(input logic [11:0] s, input logic [14:0] d);
        logic [15:0] s1;
        logic [15:0] dd;
        mode_t       m;
        s1 = (s == 12'd0) ? 16'd1 : {4'd0, s};
        dd = {1'b0, d};
        if ((s1 << 3) <= dd)                           m = 4'd8;
        else if (((s1 << 3) - s1) <= dd)               m = 4'd7;
        else if (((s1 << 2) + (s1 << 1)) <= dd)        m = 4'd6;
        else if (((s1 << 2) + s1) <= dd)               m = 4'd5;
        else if ((s1 << 2) <= dd)                      m = 4'd4;
        else if ((((s1 << 3) - s1) >> 1) <= dd)        m = MODE_F72;
        else if (((s1 << 1) + s1) <= dd)               m = 4'd3;
        else if ((((s1 << 2) + s1) >> 1) <= dd)        m = MODE_F52;
        else if ((s1 << 1) <= dd)                      m = 4'd2;
        else if ((((s1 << 1) + s1) >> 1) <= dd)        m = MODE_F32;
        else if (s1 <= dd)                             m = 4'd1;
        else                                           m = MODE_HALF;
        return m;
    endfunction

    // Blend kind of result number idx within a run pattern
    function automatic kind_t kind_of(input pat_t pat, input logic [2:0] idx);
        kind_t k;
        k = K_A;
        case (pat)
            PAT_HALF: k = K_M;
            PAT_F32: begin
                case (idx)
                    3'd0:    k = K_A;
                    3'd1:    k = K_M;
                    default: k = K_B;
                endcase
            end
            PAT_F52: begin
                case (idx)
                    3'd0:    k = K_A;
                    3'd1:    k = K_L;
                    3'd2:    k = K_M;
                    3'd3:    k = K_R;
                    default: k = K_B;
                endcase
            end
            PAT_F72: begin
                case (idx)
                    3'd0, 3'd1: k = K_A;
                    3'd2:       k = K_L;
                    3'd3:       k = K_M;
                    3'd4:       k = K_R;
                    default:    k = K_B;
                endcase
            end
            default: k = K_A;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/rss_lane.sv -----
// One color channel lane: horizontal blend on both rows, then vertical blend.
`timescale 1ns / 1ps
`default_nettype none

module rss_lane
    import rss_pkg::*;
(
    input  wire rss_lane_ctrl_t ctrl,
    input  wire logic [7:0]     a_top,
    input  wire logic [7:0]     b_top,
    input  wire logic [7:0]     a_bot,
    input  wire logic [7:0]     b_bot,
    output logic [7:0]          value
);

    logic [9:0] t_hor;
    logic [9:0] u_hor;
    logic [9:0] mid;
    logic [9:0] ver;

    function automatic logic [9:0] hblend(input kind_t k, input logic [7:0] a,
                                          input logic [7:0] b);
        logic [9:0] a10;
        logic [9:0] b10;
        logic [9:0] r;
        a10 = {2'd0, a};
        b10 = {2'd0, b};
        case (k)
            K_A:     r = a10;
            K_L:     r = ((a10 << 1) + a10 + b10) >> 2;
            K_M:     r = (a10 + b10) >> 1;
            K_R:     r = (a10 + (b10 << 1) + b10) >> 2;
            default: r = b10;
        endcase
        return r;
    endfunction

    // Horizontal step for upper and lower rows
    assign t_hor = hblend(ctrl.kind, a_top, b_top);
    assign u_hor = hblend(ctrl.kind, a_bot, b_bot);
    assign mid   = (t_hor + u_hor) >> 1;

    // Vertical step for the requested output row phase
    always_comb begin
        ver = t_hor;
        case (ctrl.vmode)
            MODE_HALF: ver = mid;
            MODE_F32: begin
                if (ctrl.phase == 3'd0)      ver = t_hor;
                else if (ctrl.phase == 3'd1) ver = mid;
                else                         ver = u_hor;
            end
            MODE_F52: begin
                case (ctrl.phase)
                    3'd0:    ver = t_hor;
                    3'd1:    ver = ((t_hor << 1) + t_hor + mid) >> 2;
                    3'd2:    ver = mid;
                    3'd3:    ver = (mid + (u_hor << 1) + u_hor) >> 2;
                    default: ver = u_hor;
                endcase
            end
            MODE_F72: begin
                case (ctrl.phase)
                    3'd0, 3'd1: ver = t_hor;
                    3'd2:       ver = ((t_hor << 1) + t_hor + u_hor) >> 2;
                    3'd3:       ver = mid;
                    3'd4:       ver = (t_hor + (u_hor << 1) + u_hor) >> 2;
                    default:    ver = u_hor;
                endcase
            end
            default: ver = t_hor;
        endcase
    end

    assign value = ver[7:0];

endmodule

`default_nettype wire

// ----- hw/rtl/rss_merge.sv -----
// Output stage: merges the three lane values and markers into one result item.
`timescale 1ns / 1ps
`default_nettype none

module rss_merge
    import rss_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        load_valid,
    output logic             load_ready,
    input  wire logic [7:0]  red,
    input  wire logic [7:0]  green,
    input  wire logic [7:0]  blue,
    input  wire rss_flags_t  flags,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // out_red, out_green, out_blue
    output logic             m_tlast,   // last_of_run
    output logic [0:0]       m_tuser    // end_of_row
);

    logic        valid_reg;
    logic [23:0] data_reg;
    rss_flags_t  flags_reg;

    assign load_ready = !valid_reg || m_tready;

    // Valid flag of the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load_ready) begin
            valid_reg <= load_valid;
        end
    end

    // Payload of the output register
    always_ff @(posedge aclk) begin
        if (load_ready && load_valid) begin
            data_reg  <= {blue, green, red};
            flags_reg <= flags;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = flags_reg.last_of_run;
    assign m_tuser  = flags_reg.end_of_row;

endmodule

`default_nettype wire

// ----- hw/rtl/rgb_step_scaler.sv -----
// Top level of the RGB step scaler: config registers, item sequencing, lanes.
`timescale 1ns / 1ps
`default_nettype none

// Each input item carries one pixel of the upper and lower source rows and the
// output row phase. It yields 0 to 8 result items, one per clock. The count is
// set by the horizontal factor:
// - integer k gives k;
// - 1.5, 2.5 and 3.5 give 3, 5 or 7 on odd columns;
// - 0.5 gives 1 on odd columns;
// - even columns of pair modes give none, except a lone last pixel, which gives
//   one copy (none at 0.5).
// The next item is taken in the cycle its predecessor issues its last result.
// Three channel lanes compute one result per cycle into the output register.
// While that result waits on m_tready the issue register stalls, and a new
// item is taken only if the issue register is empty or issues its last
// result. Factors follow from the size registers; the user must see that they
// are written over APB only while idle, which the block does not enforce.
module rgb_step_scaler
    import rss_pkg::*;
#(
    parameter int MAX_SRC_WIDTH = 2048
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input item stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // top_red, top_green, top_blue, bottom_red, bottom_green, bottom_blue,
    // out_row_phase, 5 bits zero pad
    input  wire logic [55:0] s_tdata,
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // out_red, out_green, out_blue
    output logic             m_tlast,   // last_of_run
    output logic [0:0]       m_tuser,   // end_of_row
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int          EFF_CAP_I = (MAX_SRC_WIDTH < 2048) ? MAX_SRC_WIDTH : 2048;
    localparam logic [11:0] EFF_CAP   = 12'(EFF_CAP_I);

    localparam logic [1:0] REG_SRC_WIDTH   = 2'd0;
    localparam logic [1:0] REG_DEST_WIDTH  = 2'd1;
    localparam logic [1:0] REG_SRC_HEIGHT  = 2'd2;
    localparam logic [1:0] REG_DEST_HEIGHT = 2'd3;

    // Configuration registers
    logic [11:0] src_width_reg;
    logic [14:0] dest_width_reg;
    logic [11:0] src_height_reg;
    logic [14:0] dest_height_reg;
    logic        cfg_wr;

    // Row state
    logic [10:0] column_reg;
    logic [23:0] held_top_reg;
    logic [23:0] held_bot_reg;

    // Issue register: the item being expanded into results
    logic        item_valid_reg;
    logic [23:0] at_reg;
    logic [23:0] bt_reg;
    logic [23:0] ab_reg;
    logic [23:0] bb_reg;
    pat_t        pat_reg;
    logic [3:0]  cnt_reg;
    logic [2:0]  idx_reg;
    mode_t       vm_reg;
    logic [2:0]  ph_reg;
    logic        eor_reg;

    // Accept-side decode
    logic [23:0] in_top;
    logic [23:0] in_bot;
    logic [2:0]  in_phase;
    logic [11:0] sw_nz;
    logic [11:0] eff;
    mode_t       hmode;
    mode_t       vmode;
    logic        lastcol;
    logic        acc_hold;
    logic        acc_use_held;
    logic [3:0]  acc_cnt;
    pat_t        acc_pat;
    logic        acc_eor;
    logic        s_accept;

    // Issue-side handshake
    logic           out_ready;
    logic           adv;
    logic           last_res;
    rss_lane_ctrl_t lane_ctrl;
    rss_flags_t     res_flags;
    logic [7:0]     lane_val [3];

    // APB write and read
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg   <= 12'd256;
            dest_width_reg  <= 15'd512;
            src_height_reg  <= 12'd192;
            dest_height_reg <= 15'd384;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_SRC_WIDTH:   src_width_reg   <= pwdata[11:0];
                REG_DEST_WIDTH:  dest_width_reg  <= pwdata[14:0];
                REG_SRC_HEIGHT:  src_height_reg  <= pwdata[11:0];
                REG_DEST_HEIGHT: dest_height_reg <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_SRC_WIDTH:   prdata = {20'd0, src_width_reg};
            REG_DEST_WIDTH:  prdata = {17'd0, dest_width_reg};
            REG_SRC_HEIGHT:  prdata = {20'd0, src_height_reg};
            REG_DEST_HEIGHT: prdata = {17'd0, dest_height_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // Unpack input item, pixels as {red, green, blue}
    assign in_top   = {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
    assign in_bot   = {s_tdata[31:24], s_tdata[39:32], s_tdata[47:40]};
    assign in_phase = s_tdata[50:48];

    // Effective row length and scale modes
    assign sw_nz   = (src_width_reg == 12'd0) ? 12'd1 : src_width_reg;
    assign eff     = (sw_nz > EFF_CAP) ? EFF_CAP : sw_nz;
    assign hmode   = pick_mode(eff, dest_width_reg);
    assign vmode   = pick_mode(src_height_reg, dest_height_reg);
    assign lastcol = ({1'b0, column_reg} >= (eff - 12'd1));

    // Decide the run this item starts
    always_comb begin
        acc_hold     = 1'b0;
        acc_use_held = 1'b0;
        acc_cnt      = 4'd0;
        acc_pat      = PAT_COPY;
        acc_eor      = lastcol;
        if (hmode >= 4'd1 && hmode <= 4'd8) begin
            acc_cnt = hmode;
        end else if (!column_reg[0]) begin
            if (lastcol) begin
                // lone last pixel: one copy, none when halving
                acc_cnt = (hmode != MODE_HALF) ? 4'd1 : 4'd0;
            end else begin
                acc_hold = 1'b1;
            end
        end else begin
            acc_use_held = 1'b1;
            case (hmode)
                MODE_HALF: begin
                    acc_cnt = 4'd1;
                    acc_pat = PAT_HALF;
                    acc_eor = (({1'b0, column_reg} + 12'd2) >= eff);
                end
                MODE_F32: begin
                    acc_cnt = 4'd3;
                    acc_pat = PAT_F32;
                end
                MODE_F52: begin
                    acc_cnt = 4'd5;
                    acc_pat = PAT_F52;
                end
                default: begin
                    acc_cnt = 4'd7;
                    acc_pat = PAT_F72;
                end
            endcase
        end
    end

    // Handshakes between accept, issue and output
    assign last_res = item_valid_reg && ({1'b0, idx_reg} == (cnt_reg - 4'd1));
    assign adv      = item_valid_reg && out_ready;
    assign s_tready = !item_valid_reg || (adv && last_res);
    assign s_accept = s_tvalid && s_tready;

    // Row state update on every accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg   <= 11'd0;
            held_top_reg <= 24'd0;
            held_bot_reg <= 24'd0;
        end else if (s_accept) begin
            column_reg <= lastcol ? 11'd0 : (column_reg + 11'd1);
            if (acc_hold) begin
                held_top_reg <= in_top;
                held_bot_reg <= in_bot;
            end
        end
    end

    // Issue register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            idx_reg        <= 3'd0;
        end else if (s_accept) begin
            item_valid_reg <= (acc_cnt != 4'd0);
            idx_reg        <= 3'd0;
        end else if (adv) begin
            if (last_res) begin
                item_valid_reg <= 1'b0;
            end
            idx_reg <= idx_reg + 3'd1;
        end
    end

    // Issue register payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            at_reg  <= acc_use_held ? held_top_reg : in_top;
            ab_reg  <= acc_use_held ? held_bot_reg : in_bot;
            bt_reg  <= in_top;
            bb_reg  <= in_bot;
            pat_reg <= acc_pat;
            cnt_reg <= acc_cnt;
            vm_reg  <= vmode;
            ph_reg  <= in_phase;
            eor_reg <= acc_eor;
        end
    end

    // Channel lanes, red in pixel bits 23:16
    assign lane_ctrl.kind  = kind_of(pat_reg, idx_reg);
    assign lane_ctrl.vmode = vm_reg;
    assign lane_ctrl.phase = ph_reg;

    for (genvar ch = 0; ch < 3; ch++) begin : g_lane
        rss_lane u_lane (
            .ctrl  (lane_ctrl),
            .a_top (at_reg[23 - 8*ch -: 8]),
            .b_top (bt_reg[23 - 8*ch -: 8]),
            .a_bot (ab_reg[23 - 8*ch -: 8]),
            .b_bot (bb_reg[23 - 8*ch -: 8]),
            .value (lane_val[ch])
        );
    end

    assign res_flags.last_of_run = last_res;
    assign res_flags.end_of_row  = last_res && eor_reg;

    rss_merge u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_valid (item_valid_reg),
        .load_ready (out_ready),
        .red        (lane_val[0]),
        .green      (lane_val[1]),
        .blue       (lane_val[2]),
        .flags      (res_flags),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

    // The result index never runs past the run length
    a_idx_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        item_valid_reg |-> ({1'b0, idx_reg} < cnt_reg))
        else $error("result index beyond run length");

    // A run that is not finished stays in the issue register
    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && !last_res) |=> (item_valid_reg && idx_reg == $past(idx_reg) + 3'd1))
        else $error("run ended early");

    // A stalled run holds its position
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid_reg && !out_ready) |=> (item_valid_reg && $stable(idx_reg)))
        else $error("stalled run moved");

endmodule

`default_nettype wire
